[design/mat4_transform_unit_defines.svh]
// ----------------------------------------------------------------------------
// mat4_transform_unit_defines - assertion macros
// Shared property shapes for the transform unit's checkers, clocked on clk_i
// and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MAT4_TRANSFORM_UNIT_DEFINES_SVH
`define MAT4_TRANSFORM_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define M4T_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define M4T_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/m4t_pkg.sv]
// ----------------------------------------------------------------------------
// m4t_pkg - shared types and constants
// Operation codes, data type and MAC control bundle of the transform unit.
// ----------------------------------------------------------------------------
package m4t_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    FN_LOAD  = 3'd0,
    FN_IDENT = 3'd1,
    FN_SCALE = 3'd2,
    FN_XLATE = 3'd3,
    FN_ROT   = 3'd4,
    FN_CAT   = 3'd5,
    FN_XFORM = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic mul_en;  // operands valid this cycle
    logic first;   // first term of a dot product
    logic last;    // last term of a dot product
  } mac_ctrl_t;

endpackage

[design/m4t_mac.sv]
// ----------------------------------------------------------------------------
// m4t_mac - shared multiply-accumulate unit
// One 32x32 multiply per cycle, floor shift, wide accumulate, 32-bit
// saturation of the finished dot product.
// ----------------------------------------------------------------------------
module m4t_mac #(
  parameter int FRAC_BITS = m4t_pkg::FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  m4t_pkg::mac_ctrl_t  ctrl_i,
  input  m4t_pkg::data_t      a_i,
  input  m4t_pkg::data_t      b_i,
  input  m4t_pkg::data_t      init_i,
  output logic                res_valid_o,
  output m4t_pkg::data_t      res_o
);

  localparam int DW     = m4t_pkg::DATA_W;
  localparam int PROD_W = 2 * DW;
  localparam int ACC_W  = PROD_W - FRAC_BITS + 2;
  localparam m4t_pkg::data_t SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam m4t_pkg::data_t SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] shifted;
  m4t_pkg::mac_ctrl_t       ctl_q;
  m4t_pkg::data_t           init_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  base;
  logic                     rv_q;
  logic [ACC_W-DW:0]        hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      ctl_q <= ctrl_i;
      rv_q  <= ctl_q.mul_en && ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    init_q <= init_i;
    if (ctl_q.mul_en) begin
      acc_q <= acc_d;
    end
  end

  // arithmetic shift right is the floor of the scaled product
  always_comb begin
    shifted = prod_q >>> FRAC_BITS;
    base    = ctl_q.first ? ACC_W'(init_q) : acc_q;
    acc_d   = base + shifted[ACC_W-1:0];
  end

  assign hi          = acc_q[ACC_W-1:DW-1];
  assign res_valid_o = rv_q;
  assign res_o       = ((&hi) || !(|hi)) ? acc_q[DW-1:0]
                     : (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX);

endmodule

[design/mat4_transform_unit.sv]
// ----------------------------------------------------------------------------
// mat4_transform_unit - 4x4 homogeneous transform matrix unit
// Holds a column-major Q16.16 matrix, builds identity, scaling, translation
// and rotation matrices, concatenates a right-hand matrix and transforms
// points, all products going through one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   channel | handshake                    | payload
//   --------+------------------------------+--------------------------------
//   in      | in_valid_i / in_stall_o      | func, elem_index, elem_value,
//           |                              | axis, cosine, sine, point_x/y/z
//   out     | out_valid_o / out_stall_i    | out_x, out_y, out_z
//
// Load, identity, scaling, translation, rotation and a non-final concatenate
// element complete on accept. A transform issues three terms per row for
// rows x, y and z to the single 32x32 multiplier and drains the MAC, and
// concatenate element 15 does the same with four terms for each of 16 results.
// Reset loads the identity matrix and empties the output register.
// A stalled output holds its transaction; a finished transform waits for the
// output register to free up before the block takes its next transaction.
// ----------------------------------------------------------------------------
module mat4_transform_unit #(
  parameter int FRAC_BITS = m4t_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           func_i,
  input  logic [3:0]           elem_index_i,
  input  logic signed [31:0]   elem_value_i,
  input  logic [1:0]           axis_i,
  input  logic signed [17:0]   cosine_i,
  input  logic signed [17:0]   sine_i,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  input  logic signed [31:0]   point_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   out_x_o,
  output logic signed [31:0]   out_y_o,
  output logic signed [31:0]   out_z_o
);

  localparam m4t_pkg::data_t ONE_VAL = m4t_pkg::data_t'(1) << FRAC_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_XISS  = 3'd1;  // transform: issue products
  localparam logic [2:0] ST_XWAIT = 3'd2;  // transform: drain the MAC
  localparam logic [2:0] ST_XOUT  = 3'd3;  // transform: wait for output reg
  localparam logic [2:0] ST_CISS  = 3'd4;  // concatenate: issue products
  localparam logic [2:0] ST_CWAIT = 3'd5;  // concatenate: drain the MAC

  // Identity element: diagonal positions have equal row and column.
  function automatic m4t_pkg::data_t ident_val(input logic [3:0] idx);
    return (idx[1:0] == idx[3:2]) ? ONE_VAL : '0;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [1:0]          iss_r_q, iss_r_d;
  logic [1:0]          iss_c_q, iss_c_d;
  logic [1:0]          iss_k_q, iss_k_d;
  logic [3:0]          res_cnt_q;
  m4t_pkg::data_t      cur_q [16];
  m4t_pkg::data_t      cur_d [16];
  m4t_pkg::data_t      right_q [16];
  m4t_pkg::data_t      px_q, py_q, pz_q;
  m4t_pkg::data_t      h0_q, h1_q, h2_q;
  m4t_pkg::data_t      out_x_q, out_y_q, out_z_q;
  logic                out_valid_q;

  logic                in_acc;
  logic                x_iss;
  logic                cat_mode;
  logic                cat_wb;
  logic                x_done;
  logic                out_free;
  logic                load_out;
  logic [1:0]          wr_r;
  m4t_pkg::data_t      cos_ext, sin_ext, sin_neg;
  m4t_pkg::data_t      pnt_sel;

  m4t_pkg::mac_ctrl_t  mac_ctrl;
  m4t_pkg::data_t      mac_a, mac_b, mac_init;
  logic                mac_res_valid;
  m4t_pkg::data_t      mac_res;

  // --------------------------------------------------------------------------
  // Handshake and status
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign x_iss      = (state_q == ST_XISS);
  assign cat_mode   = (state_q == ST_CISS) || (state_q == ST_CWAIT);
  assign wr_r       = res_cnt_q[3:2];
  assign cat_wb     = mac_res_valid && cat_mode && (res_cnt_q[1:0] == 2'd3);
  assign x_done     = (state_q == ST_XWAIT) && mac_res_valid && (res_cnt_q == 4'd2);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (x_done || (state_q == ST_XOUT)) && out_free;

  assign cos_ext = m4t_pkg::data_t'(cosine_i);
  assign sin_ext = m4t_pkg::data_t'(sine_i);
  assign sin_neg = -sin_ext;

  // --------------------------------------------------------------------------
  // Sequencer: walk rows, columns and terms
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    iss_r_d = iss_r_q;
    iss_c_d = iss_c_q;
    iss_k_d = iss_k_q;
    case (state_q)
      ST_IDLE: begin
        iss_r_d = 2'd0;
        iss_c_d = 2'd0;
        iss_k_d = 2'd0;
        if (in_acc && (func_i == m4t_pkg::FN_XFORM)) begin
          state_d = ST_XISS;
        end else if (in_acc && (func_i == m4t_pkg::FN_CAT) && (elem_index_i == 4'd15)) begin
          state_d = ST_CISS;
        end
      end
      ST_XISS: begin
        // three terms per row, rows x, y, z
        if (iss_k_q == 2'd2) begin
          iss_k_d = 2'd0;
          iss_r_d = iss_r_q + 2'd1;
          if (iss_r_q == 2'd2) begin
            state_d = ST_XWAIT;
          end
        end else begin
          iss_k_d = iss_k_q + 2'd1;
        end
      end
      ST_XWAIT: begin
        if (x_done) begin
          state_d = out_free ? ST_IDLE : ST_XOUT;
        end
      end
      ST_XOUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CISS: begin
        // k fastest, then column, then row: a row finishes before the next
        iss_k_d = iss_k_q + 2'd1;
        if (iss_k_q == 2'd3) begin
          iss_c_d = iss_c_q + 2'd1;
          if (iss_c_q == 2'd3) begin
            iss_r_d = iss_r_q + 2'd1;
            if (iss_r_q == 2'd3) begin
              state_d = ST_CWAIT;
            end
          end
        end
      end
      ST_CWAIT: begin
        if (mac_res_valid && (res_cnt_q == 4'd15)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_r_q   <= 2'd0;
      iss_c_q   <= 2'd0;
      iss_k_q   <= 2'd0;
      res_cnt_q <= 4'd0;
    end else begin
      state_q <= state_d;
      iss_r_q <= iss_r_d;
      iss_c_q <= iss_c_d;
      iss_k_q <= iss_k_d;
      if (in_acc) begin
        res_cnt_q <= 4'd0;
      end else if (mac_res_valid) begin
        res_cnt_q <= res_cnt_q + 4'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Operand selection for the shared MAC
  // --------------------------------------------------------------------------
  always_comb begin
    case (iss_k_q)
      2'd0:    pnt_sel = px_q;
      2'd1:    pnt_sel = py_q;
      default: pnt_sel = pz_q;
    endcase
  end

  always_comb begin
    mac_ctrl.mul_en = x_iss || (state_q == ST_CISS);
    mac_ctrl.first  = (iss_k_q == 2'd0);
    mac_ctrl.last   = x_iss ? (iss_k_q == 2'd2) : (iss_k_q == 2'd3);
    // left operand is current[row + 4*k] in both modes
    mac_a    = cur_q[{iss_k_q, iss_r_q}];
    mac_b    = x_iss ? pnt_sel : right_q[{iss_c_q, iss_k_q}];
    // translation column seeds the transform sum
    mac_init = x_iss ? cur_q[{2'd3, iss_r_q}] : '0;
  end

  m4t_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .a_i         (mac_a),
    .b_i         (mac_b),
    .init_i      (mac_init),
    .res_valid_o (mac_res_valid),
    .res_o       (mac_res)
  );

  // --------------------------------------------------------------------------
  // Current matrix: direct builds on accept, row writeback on concatenate
  // --------------------------------------------------------------------------
  always_comb begin
    cur_d = cur_q;
    if (in_acc) begin
      case (func_i)
        m4t_pkg::FN_LOAD: begin
          cur_d[elem_index_i] = elem_value_i;
        end
        m4t_pkg::FN_IDENT: begin
          for (int i = 0; i < 16; i++) cur_d[i] = ident_val(4'(i));
        end
        m4t_pkg::FN_SCALE: begin
          for (int i = 0; i < 16; i++) cur_d[i] = ident_val(4'(i));
          cur_d[0]  = point_x_i;
          cur_d[5]  = point_y_i;
          cur_d[10] = point_z_i;
        end
        m4t_pkg::FN_XLATE: begin
          for (int i = 0; i < 16; i++) cur_d[i] = ident_val(4'(i));
          cur_d[12] = point_x_i;
          cur_d[13] = point_y_i;
          cur_d[14] = point_z_i;
        end
        m4t_pkg::FN_ROT: begin
          case (axis_i)
            m4t_pkg::AX_X: begin
              for (int i = 0; i < 16; i++) cur_d[i] = ident_val(4'(i));
              cur_d[5]  = cos_ext;
              cur_d[6]  = sin_ext;
              cur_d[9]  = sin_neg;
              cur_d[10] = cos_ext;
            end
            m4t_pkg::AX_Y: begin
              for (int i = 0; i < 16; i++) cur_d[i] = ident_val(4'(i));
              cur_d[0]  = cos_ext;
              cur_d[2]  = sin_neg;
              cur_d[8]  = sin_ext;
              cur_d[10] = cos_ext;
            end
            m4t_pkg::AX_Z: begin
              for (int i = 0; i < 16; i++) cur_d[i] = ident_val(4'(i));
              cur_d[0]  = cos_ext;
              cur_d[1]  = sin_ext;
              cur_d[4]  = sin_neg;
              cur_d[5]  = cos_ext;
            end
            default: begin
              // unused axis code: leave the matrix alone
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    // A finished result row replaces its row of the current matrix; later
    // rows never read it again.
    if (cat_wb) begin
      cur_d[{2'd0, wr_r}] = h0_q;
      cur_d[{2'd1, wr_r}] = h1_q;
      cur_d[{2'd2, wr_r}] = h2_q;
      cur_d[{2'd3, wr_r}] = mac_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) cur_q[i] <= ident_val(4'(i));
    end else begin
      cur_q <= cur_d;
    end
  end

  // --------------------------------------------------------------------------
  // Right-hand matrix, point latch and partial results
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc && (func_i == m4t_pkg::FN_CAT)) begin
      right_q[elem_index_i] <= elem_value_i;
    end
    if (in_acc) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      pz_q <= point_z_i;
    end
    // hold finished dot products until the row or point is complete
    if (mac_res_valid) begin
      case (res_cnt_q[1:0])
        2'd0:    h0_q <= mac_res;
        2'd1:    h1_q <= mac_res;
        2'd2:    h2_q <= mac_res;
        default: begin
        end
      endcase
    end
    // z comes straight from the MAC, which holds it until the next issue
    if (load_out) begin
      out_x_q <= h0_q;
      out_y_q <= h1_q;
      out_z_q <= mac_res;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

endmodule

[design/m4t_checker.sv]
// ----------------------------------------------------------------------------
// m4t_checker - port-level checks of the transform unit
// Watches both channels and flags lost results and wrong busy behavior.
// ----------------------------------------------------------------------------
`include "mat4_transform_unit_defines.svh"

module m4t_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic [2:0]           func_i,
  input  logic [3:0]           elem_index_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic signed [31:0]   out_x_o,
  input  logic signed [31:0]   out_y_o,
  input  logic signed [31:0]   out_z_o
);

  logic        in_acc;
  logic        out_held;
  logic        xform_acc;
  logic        quick_op;
  logic [95:0] out_bus;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign xform_acc = in_acc && (func_i == m4t_pkg::FN_XFORM);
  assign quick_op  = in_acc && !xform_acc &&
                     ((func_i != m4t_pkg::FN_CAT) || (elem_index_i != 4'd15));
  assign out_bus   = {out_x_o, out_y_o, out_z_o};

  `M4T_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "stalled result dropped")

  `M4T_ASSERT_NEXT(a_out_stable, out_held, $stable(out_bus), "stalled result changed")

  // operations that finish on accept leave the block free at once
  `M4T_ASSERT_NEXT(a_quick_op, quick_op, !in_stall_o, "single-cycle op kept block busy")

  `M4T_ASSERT_NEXT(a_xform_busy, xform_acc, in_stall_o, "transform did not hold off input")

  // no result can appear the cycle after a transaction is taken
  `M4T_ASSERT_NEXT(a_no_early_out, in_acc, !$rose(out_valid_o), "result appeared too early")

endmodule

bind mat4_transform_unit m4t_checker u_m4t_checker (.*);
